@@ hw/rtl/rsi_pkg.sv @@
// ----------------------------------------------------------------------------
// rsi_pkg
// shared widths, types and register codes of the ray/sphere intersect block
// ----------------------------------------------------------------------------
`default_nettype none

package rsi_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int CFG_IDX_W     = 3;
    localparam int A_W           = 64;
    localparam int B_W           = 66;
    localparam int K_W           = 67;
    localparam int ROOT_W        = 67;
    localparam int DISC_W        = 2 * ROOT_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTER_X = 3'd0,
        REG_CENTER_Y = 3'd1,
        REG_CENTER_Z = 3'd2,
        REG_RADIUS   = 3'd3
    } cfg_reg_t;

    typedef struct packed {
        logic signed [31:0] t_min;
        logic signed [31:0] t_max;
        logic               miss;
    } side_t;

    typedef struct packed {
        logic        [A_W-1:0] a;
        logic signed [B_W-1:0] b;
        side_t                 side;
    } carry_t;

endpackage

`default_nettype wire

@@ hw/rtl/rsi_channels.sv @@
// ----------------------------------------------------------------------------
// rsi_channels
// valid/ready channels for rays in and hit results out
// ----------------------------------------------------------------------------
`default_nettype none

interface rsi_ray_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic signed [31:0] t_min;
    logic signed [31:0] t_max;

    modport source (
        output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, t_min, t_max,
        input  ready
    );
    modport sink (
        input  valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, t_min, t_max,
        output ready
    );
endinterface

interface rsi_hit_if;
    logic               valid;
    logic               ready;
    logic               hit;
    logic signed [31:0] t_hit;

    modport source (output valid, hit, t_hit, input ready);
    modport sink   (input valid, hit, t_hit, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/rsi_front.sv @@
// ----------------------------------------------------------------------------
// rsi_front
// dot products and discriminant, six register stages
// ----------------------------------------------------------------------------
`default_nettype none

module rsi_front
    import rsi_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    adv,
    input  wire logic                    in_valid,
    input  wire logic signed [31:0]      origin_x,
    input  wire logic signed [31:0]      origin_y,
    input  wire logic signed [31:0]      origin_z,
    input  wire logic signed [31:0]      dir_x,
    input  wire logic signed [31:0]      dir_y,
    input  wire logic signed [31:0]      dir_z,
    input  wire logic signed [31:0]      t_min,
    input  wire logic signed [31:0]      t_max,
    input  wire logic signed [31:0]      center_x,
    input  wire logic signed [31:0]      center_y,
    input  wire logic signed [31:0]      center_z,
    input  wire logic        [30:0]      radius,
    output logic                         out_valid,
    output logic signed [DISC_W-1:0]     disc,
    output carry_t                       carry
);

    logic v0_reg, v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;

    logic signed [31:0] d_reg [3];
    logic signed [32:0] w_reg [3];
    side_t              s0_reg;

    logic signed [63:0] paa_reg [3];
    logic signed [64:0] pb_reg [3];
    logic signed [65:0] pw_reg [3];
    logic        [61:0] r2_reg;
    side_t              s1_reg;

    carry_t             c2_reg;
    logic signed [K_W-1:0] k2_reg;

    logic signed [65:0] pbhh_reg;
    logic signed [66:0] pbhl_reg;
    logic        [65:0] pbll_reg;
    logic signed [65:0] pahkh_reg;
    logic        [65:0] pahkl_reg;
    logic signed [65:0] palkh_reg;
    logic        [65:0] palkl_reg;
    carry_t             c3_reg;

    logic signed [DISC_W-1:0] bb_reg;
    logic signed [DISC_W-1:0] ak_reg;
    carry_t                   c4_reg;

    logic signed [DISC_W-1:0] disc_reg;
    carry_t                   c5_reg;

    logic signed [32:0] bh;
    logic        [32:0] bl;
    logic        [31:0] ah;
    logic        [31:0] al;
    logic signed [32:0] kh;
    logic        [33:0] kl;
    logic signed [DISC_W-1:0] disc_next;

    always_comb
    begin
        bh        = $signed(c2_reg.b[65:33]);
        bl        = c2_reg.b[32:0];
        ah        = c2_reg.a[63:32];
        al        = c2_reg.a[31:0];
        kh        = $signed(k2_reg[66:34]);
        kl        = k2_reg[33:0];
        disc_next = bb_reg - ak_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (adv)
        begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // stage 0: offsets to the center
            d_reg[0]     <= dir_x;
            d_reg[1]     <= dir_y;
            d_reg[2]     <= dir_z;
            w_reg[0]     <= 33'(center_x) - 33'(origin_x);
            w_reg[1]     <= 33'(center_y) - 33'(origin_y);
            w_reg[2]     <= 33'(center_z) - 33'(origin_z);
            s0_reg.t_min <= t_min;
            s0_reg.t_max <= t_max;
            s0_reg.miss  <= 1'b0;

            // stage 1: products
            for (int i = 0; i < 3; i++)
            begin
                paa_reg[i] <= d_reg[i] * d_reg[i];
                pb_reg[i]  <= d_reg[i] * w_reg[i];
                pw_reg[i]  <= w_reg[i] * w_reg[i];
            end
            r2_reg <= radius * radius;
            s1_reg <= s0_reg;

            // stage 2: sums
            c2_reg.a    <= $unsigned(paa_reg[0]) + $unsigned(paa_reg[1])
                           + $unsigned(paa_reg[2]);
            c2_reg.b    <= 66'(pb_reg[0]) + 66'(pb_reg[1]) + 66'(pb_reg[2]);
            c2_reg.side <= s1_reg;
            k2_reg      <= 67'(pw_reg[0]) + 67'(pw_reg[1]) + 67'(pw_reg[2]) - 67'(r2_reg);

            // stage 3: partial products of b*b and a*k
            pbhh_reg  <= bh * bh;
            pbhl_reg  <= bh * $signed({1'b0, bl});
            pbll_reg  <= bl * bl;
            pahkh_reg <= $signed({1'b0, ah}) * kh;
            pahkl_reg <= ah * kl;
            palkh_reg <= $signed({1'b0, al}) * kh;
            palkl_reg <= al * kl;
            c3_reg    <= c2_reg;

            // stage 4: recombine
            bb_reg <= (DISC_W'(pbhh_reg) <<< 66) + (DISC_W'(pbhl_reg) <<< 34)
                      + DISC_W'(pbll_reg);
            ak_reg <= (DISC_W'(pahkh_reg) <<< 66) + (DISC_W'(pahkl_reg) <<< 32)
                      + (DISC_W'(palkh_reg) <<< 34) + DISC_W'(palkl_reg);
            c4_reg <= c3_reg;

            // stage 5: discriminant and early miss
            disc_reg         <= disc_next;
            c5_reg.a         <= c4_reg.a;
            c5_reg.b         <= c4_reg.b;
            c5_reg.side.t_min <= c4_reg.side.t_min;
            c5_reg.side.t_max <= c4_reg.side.t_max;
            c5_reg.side.miss <= (c4_reg.a == '0) || disc_next[DISC_W-1];
        end
    end

    assign out_valid = v5_reg;
    assign disc      = disc_reg;
    assign carry     = c5_reg;

endmodule

`default_nettype wire

@@ hw/rtl/rsi_sqrt.sv @@
// ----------------------------------------------------------------------------
// rsi_sqrt
// pipelined integer square root, one root bit per stage
// ----------------------------------------------------------------------------
`default_nettype none

module rsi_sqrt
    import rsi_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              adv,
    input  wire logic              in_valid,
    input  wire logic [DISC_W-1:0] rad,
    input  wire carry_t            carry_in,
    output logic                   out_valid,
    output logic [ROOT_W-1:0]      root,
    output carry_t                 carry_out
);

    localparam int RW = ROOT_W + 3;

    logic              v_reg    [ROOT_W];
    logic [RW-1:0]     rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    logic [DISC_W-1:0] rad_reg  [ROOT_W];
    carry_t            c_reg    [ROOT_W];

    for (genvar g = 0; g < ROOT_W; g++)
    begin : g_stage
        logic              v_prev;
        logic [RW-1:0]     rem_prev;
        logic [ROOT_W-1:0] root_prev;
        logic [DISC_W-1:0] rad_prev;
        carry_t            c_prev;
        logic [RW-1:0]     rem_sh;
        logic [RW-1:0]     trial;
        logic [RW-1:0]     rem_next;
        logic [ROOT_W-1:0] root_next;

        if (g == 0)
        begin : g_first
            assign v_prev    = in_valid;
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign rad_prev  = rad;
            assign c_prev    = carry_in;
        end
        else
        begin : g_rest
            assign v_prev    = v_reg[g-1];
            assign rem_prev  = rem_reg[g-1];
            assign root_prev = root_reg[g-1];
            assign rad_prev  = rad_reg[g-1];
            assign c_prev    = c_reg[g-1];
        end

        always_comb
        begin
            rem_sh = {rem_prev[RW-3:0], rad_prev[DISC_W-1 -: 2]};
            trial  = {1'b0, root_prev, 2'b01};
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {root_prev[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {root_prev[ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[g] <= 1'b0;
            end
            else if (adv)
            begin
                v_reg[g] <= v_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[g]  <= rem_next;
                root_reg[g] <= root_next;
                rad_reg[g]  <= rad_prev << 2;
                c_reg[g]    <= c_prev;
            end
        end
    end

    assign out_valid = v_reg[ROOT_W-1];
    assign root      = root_reg[ROOT_W-1];
    assign carry_out = c_reg[ROOT_W-1];

endmodule

`default_nettype wire

@@ hw/rtl/rsi_div.sv @@
// ----------------------------------------------------------------------------
// rsi_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
`default_nettype none

module rsi_div
    import rsi_pkg::*;
#(
    parameter int MAG_W  = ROOT_W + 1 + FRAC_BITS_DEF,
    parameter int SIDE_W = 1
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              adv,
    input  wire logic              in_valid,
    input  wire logic [MAG_W-1:0]  mag,
    input  wire logic [A_W-1:0]    den,
    input  wire logic [SIDE_W-1:0] side_in,
    output logic                   out_valid,
    output logic [MAG_W-1:0]       quot,
    output logic                   rem_nz,
    output logic [SIDE_W-1:0]      side_out
);

    localparam int RW = A_W + 1;

    logic              v_reg   [MAG_W];
    logic [RW-1:0]     rem_reg [MAG_W];
    logic [MAG_W-1:0]  q_reg   [MAG_W];
    logic [MAG_W-1:0]  m_reg   [MAG_W];
    logic [A_W-1:0]    den_reg [MAG_W];
    logic [SIDE_W-1:0] s_reg   [MAG_W];

    for (genvar g = 0; g < MAG_W; g++)
    begin : g_stage
        logic              v_prev;
        logic [RW-1:0]     rem_prev;
        logic [MAG_W-1:0]  q_prev;
        logic [MAG_W-1:0]  m_prev;
        logic [A_W-1:0]    den_prev;
        logic [SIDE_W-1:0] s_prev;
        logic [RW-1:0]     rem_sh;
        logic [RW-1:0]     rem_next;
        logic              q_bit;

        if (g == 0)
        begin : g_first
            assign v_prev   = in_valid;
            assign rem_prev = '0;
            assign q_prev   = '0;
            assign m_prev   = mag;
            assign den_prev = den;
            assign s_prev   = side_in;
        end
        else
        begin : g_rest
            assign v_prev   = v_reg[g-1];
            assign rem_prev = rem_reg[g-1];
            assign q_prev   = q_reg[g-1];
            assign m_prev   = m_reg[g-1];
            assign den_prev = den_reg[g-1];
            assign s_prev   = s_reg[g-1];
        end

        always_comb
        begin
            rem_sh = {rem_prev[A_W-1:0], m_prev[MAG_W-1]};
            q_bit  = (rem_sh >= {1'b0, den_prev});
            if (q_bit)
            begin
                rem_next = rem_sh - {1'b0, den_prev};
            end
            else
            begin
                rem_next = rem_sh;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[g] <= 1'b0;
            end
            else if (adv)
            begin
                v_reg[g] <= v_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[g] <= rem_next;
                q_reg[g]   <= {q_prev[MAG_W-2:0], q_bit};
                m_reg[g]   <= m_prev << 1;
                den_reg[g] <= den_prev;
                s_reg[g]   <= s_prev;
            end
        end
    end

    assign out_valid = v_reg[MAG_W-1];
    assign quot      = q_reg[MAG_W-1];
    assign rem_nz    = |rem_reg[MAG_W-1];
    assign side_out  = s_reg[MAG_W-1];

endmodule

`default_nettype wire

@@ hw/rtl/ray_sphere_intersect_top.sv @@
// throughput: one ray per cycle; every stage moves together, and the whole pipe
// holds while a finished result is not taken at the output register
// depth is set by the square root (67 stages) and the divider (68 + FRAC_BITS stages)
// reset clears all valid bits and the sphere registers to zero
// ----------------------------------------------------------------------------
// ray_sphere_intersect_top
// nearest ray/sphere hit inside the ray interval, fixed point
// ----------------------------------------------------------------------------
`default_nettype none

module ray_sphere_intersect_top
    import rsi_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]          cfg_data,
    rsi_ray_if.sink                   ray,
    rsi_hit_if.source                 res
);

    localparam int DW    = ROOT_W + 2;
    localparam int MAG_W = DW - 1 + FRAC_BITS;
    localparam int QW    = MAG_W + 1;
    localparam int SW1   = $bits(side_t) + 1;

    logic signed [31:0] center_x_reg, center_y_reg, center_z_reg;
    logic        [30:0] radius_reg;

    logic adv;

    logic                     fr_valid;
    logic signed [DISC_W-1:0] fr_disc;
    carry_t                   fr_carry;

    logic                     sq_valid;
    logic [ROOT_W-1:0]        sq_root;
    carry_t                   sq_carry;

    logic                     n_v_reg;
    logic [MAG_W-1:0]         n_mag1_reg, n_mag2_reg;
    logic                     n_neg1_reg, n_neg2_reg;
    carry_t                   n_c_reg;
    logic signed [DW-1:0]     d1, d2, abs1, abs2;

    logic                     dv1_valid, dv2_valid;
    logic [MAG_W-1:0]         dv1_q, dv2_q;
    logic                     dv1_nz, dv2_nz;
    logic [SW1-1:0]           dv1_side;
    logic                     dv2_neg;
    side_t                    dv_side;
    logic                     dv1_neg;

    logic signed [QW-1:0]     q1, q2;
    logic                     f_v_reg;
    logic                     f_inr1_reg, f_inr2_reg;
    logic signed [31:0]       f_t1_reg, f_t2_reg;
    side_t                    f_side_reg;

    logic                     hit1, hit2;
    logic                     out_v_reg;
    logic                     out_hit_reg;
    logic signed [31:0]       out_t_reg;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            center_z_reg <= '0;
            radius_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_CENTER_X: center_x_reg <= cfg_data;
                REG_CENTER_Y: center_y_reg <= cfg_data;
                REG_CENTER_Z: center_z_reg <= cfg_data;
                REG_RADIUS:   radius_reg   <= cfg_data[30:0];
                default:      ;
            endcase
        end
    end

    // whole pipe advances unless the output holds an untaken result
    assign adv       = !out_v_reg || res.ready;
    assign ray.ready = adv;

    rsi_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (ray.valid),
        .origin_x  (ray.origin_x),
        .origin_y  (ray.origin_y),
        .origin_z  (ray.origin_z),
        .dir_x     (ray.dir_x),
        .dir_y     (ray.dir_y),
        .dir_z     (ray.dir_z),
        .t_min     (ray.t_min),
        .t_max     (ray.t_max),
        .center_x  (center_x_reg),
        .center_y  (center_y_reg),
        .center_z  (center_z_reg),
        .radius    (radius_reg),
        .out_valid (fr_valid),
        .disc      (fr_disc),
        .carry     (fr_carry)
    );

    rsi_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (fr_valid),
        .rad       (fr_disc),
        .carry_in  (fr_carry),
        .out_valid (sq_valid),
        .root      (sq_root),
        .carry_out (sq_carry)
    );

    // numerators (b -/+ s) scaled, as sign and magnitude
    always_comb
    begin
        d1   = DW'(sq_carry.b) - DW'(sq_root);
        d2   = DW'(sq_carry.b) + DW'(sq_root);
        abs1 = d1[DW-1] ? -d1 : d1;
        abs2 = d2[DW-1] ? -d2 : d2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            n_v_reg <= sq_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            n_mag1_reg <= {abs1[DW-2:0], {FRAC_BITS{1'b0}}};
            n_mag2_reg <= {abs2[DW-2:0], {FRAC_BITS{1'b0}}};
            n_neg1_reg <= d1[DW-1];
            n_neg2_reg <= d2[DW-1];
            n_c_reg    <= sq_carry;
        end
    end

    rsi_div #(
        .MAG_W  (MAG_W),
        .SIDE_W (SW1)
    ) u_div_near (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (n_v_reg),
        .mag       (n_mag1_reg),
        .den       (n_c_reg.a),
        .side_in   ({n_c_reg.side, n_neg1_reg}),
        .out_valid (dv1_valid),
        .quot      (dv1_q),
        .rem_nz    (dv1_nz),
        .side_out  (dv1_side)
    );

    rsi_div #(
        .MAG_W  (MAG_W),
        .SIDE_W (1)
    ) u_div_far (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (n_v_reg),
        .mag       (n_mag2_reg),
        .den       (n_c_reg.a),
        .side_in   (n_neg2_reg),
        .out_valid (dv2_valid),
        .quot      (dv2_q),
        .rem_nz    (dv2_nz),
        .side_out  (dv2_neg)
    );

    // floor quotients and range check
    always_comb
    begin
        dv_side = dv1_side[SW1-1:1];
        dv1_neg = dv1_side[0];
        q1 = dv1_neg ? -(QW'(dv1_q) + QW'(dv1_nz)) : QW'(dv1_q);
        q2 = dv2_neg ? -(QW'(dv2_q) + QW'(dv2_nz)) : QW'(dv2_q);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            f_v_reg <= dv1_valid && dv2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f_inr1_reg <= (q1[QW-1:31] == '0) || (q1[QW-1:31] == '1);
            f_inr2_reg <= (q2[QW-1:31] == '0) || (q2[QW-1:31] == '1);
            f_t1_reg   <= q1[31:0];
            f_t2_reg   <= q2[31:0];
            f_side_reg <= dv_side;
        end
    end

    // interval test, nearer root first
    always_comb
    begin
        hit1 = !f_side_reg.miss && f_inr1_reg
               && (f_t1_reg >= f_side_reg.t_min) && (f_t1_reg <= f_side_reg.t_max);
        hit2 = !f_side_reg.miss && f_inr2_reg
               && (f_t2_reg >= f_side_reg.t_min) && (f_t2_reg <= f_side_reg.t_max);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_v_reg <= f_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_hit_reg <= hit1 || hit2;
            if (hit1)
            begin
                out_t_reg <= f_t1_reg;
            end
            else if (hit2)
            begin
                out_t_reg <= f_t2_reg;
            end
            else
            begin
                out_t_reg <= '0;
            end
        end
    end

    assign res.valid = out_v_reg;
    assign res.hit   = out_hit_reg;
    assign res.t_hit = out_t_reg;

endmodule

`default_nettype wire

@@ hw/rtl/rsi_checker.sv @@
// ----------------------------------------------------------------------------
// rsi_checker
// port-level checks of the intersect block, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module rsi_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        ray_ready,
    input wire logic        res_valid,
    input wire logic        res_ready,
    input wire logic        res_hit,
    input wire logic [31:0] res_t_hit
);

    // a result waiting for transfer stays
    a_res_held: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(res_hit) && $stable(res_t_hit))
        else $error("result changed while stalled");

    // a miss reports zero
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_hit |-> res_t_hit == 32'd0)
        else $error("miss with nonzero t");

    // input only blocks on output backpressure
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !ray_ready |-> res_valid && !res_ready)
        else $error("input stalled without output backpressure");

endmodule

bind ray_sphere_intersect_top rsi_checker u_rsi_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .ray_ready (ray.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .res_hit   (res.hit),
    .res_t_hit (res.t_hit)
);

`default_nettype wire

@@ dv/ray_sphere_intersect_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ray_sphere_intersect_top_tb
// self-checking bench for the ray/sphere intersect block: a scoreboard
// computes the nearest root in wide exact integers for every ray transfer and
// compares it with each hit transfer, over several sphere settings, directed
// corner rays and random rays, with random stalls on both channels
// ----------------------------------------------------------------------------
`default_nettype none

module ray_sphere_intersect_top_tb
    import rsi_pkg::*;
;

    localparam int FRAC = FRAC_BITS_DEF;
    localparam int DRAIN_CYCLES = 144 + FRAC + 40;

    typedef logic signed [191:0] wide_t;

    typedef struct packed {
        logic signed [31:0] ox, oy, oz, dx, dy, dz, t_lo, t_hi;
    } ray_t;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] t;
    } hit_t;

    class hit_scoreboard;
        logic signed [31:0] cx, cy, cz;
        logic [30:0]        rad;
        hit_t               hits_due[$];
        int                 errors;

        function new();
            cx = 0; cy = 0; cz = 0; rad = 0; errors = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
            case (idx)
                REG_CENTER_X: cx = data;
                REG_CENTER_Y: cy = data;
                REG_CENTER_Z: cz = data;
                REG_RADIUS:   rad = data[30:0];
                default: ;
            endcase
        endfunction

        function wide_t floor_sqrt(wide_t v);
            wide_t acc, trial;
            acc = 0;
            for (int bit_i = 71; bit_i >= 0; bit_i--)
            begin
                trial = acc | (wide_t'(1) <<< bit_i);
                if (trial * trial <= v)
                    acc = trial;
            end
            return acc;
        endfunction

        function bit root_in_range(wide_t num, wide_t den, ray_t r, output logic signed [31:0] t);
            wide_t q;
            q = num / den;
            if ((num % den) != 0 && num < 0)
                q = q - 1;
            t = q[31:0];
            if (q < -(wide_t'(1) <<< 31) || q > (wide_t'(1) <<< 31) - 1)
                return 0;
            return (q >= wide_t'(r.t_lo)) && (q <= wide_t'(r.t_hi));
        endfunction

        function void note_ray(ray_t r);
            wide_t dx, dy, dz, wx, wy, wz, rr, a, b, k, disc, s;
            hit_t  e;
            logic signed [31:0] t;
            e = '0;
            dx = r.dx; dy = r.dy; dz = r.dz;
            wx = wide_t'(cx) - wide_t'(r.ox);
            wy = wide_t'(cy) - wide_t'(r.oy);
            wz = wide_t'(cz) - wide_t'(r.oz);
            rr = {161'b0, rad};
            a = dx * dx + dy * dy + dz * dz;
            if (a != 0)
            begin
                b = dx * wx + dy * wy + dz * wz;
                k = wx * wx + wy * wy + wz * wz - rr * rr;
                disc = b * b - a * k;
                if (disc >= 0)
                begin
                    s = floor_sqrt(disc);
                    if (root_in_range((b - s) <<< FRAC, a, r, t))
                        e = '{1'b1, t};
                    else if (root_in_range((b + s) <<< FRAC, a, r, t))
                        e = '{1'b1, t};
                end
            end
            hits_due.push_back(e);
        endfunction

        task report(string what);
            errors++;
            $display("mismatch at %0t: %s", $time, what);
        endtask

        task check_hit(logic hit, logic signed [31:0] t);
            hit_t e;
            if (hits_due.size() == 0)
            begin
                report($sformatf("unexpected result hit=%0b t=%0d", hit, t));
                return;
            end
            e = hits_due.pop_front();
            if (hit !== e.hit)
                report($sformatf("hit %0b, expected %0b", hit, e.hit));
            if (t !== e.t)
                report($sformatf("t_hit %0d, expected %0d", t, e.t));
        endtask
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_data;
    bit                   no_idle;

    rsi_ray_if ray_ch();
    rsi_hit_if hit_ch();

    hit_scoreboard sb;

    ray_sphere_intersect_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ray       (ray_ch),
        .res       (hit_ch)
    );

    always #10 clk = ~clk;

    function bit take_break();
        return !no_idle && ($urandom_range(99) < 35);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && hit_ch.valid && hit_ch.ready)
            sb.check_hit(hit_ch.hit, hit_ch.t_hit);
        hit_ch.ready <= rst_n && !take_break();
    end

    task write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.set_reg(idx, data);
    endtask

    task wait_drained();
        ray_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.hits_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task set_sphere(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic [31:0] r);
        wait_drained();
        write_reg(REG_CENTER_X, x);
        write_reg(REG_CENTER_Y, y);
        write_reg(REG_CENTER_Z, z);
        write_reg(REG_RADIUS, r);
        write_reg(CFG_IDX_W'(REG_RADIUS) + CFG_IDX_W'($urandom_range(1, 4)), $urandom);
        cfg_we <= 1'b0;
    endtask

    task send_ray(ray_t r);
        while (take_break())
        begin
            ray_ch.valid <= 1'b0;
            @(posedge clk);
        end
        ray_ch.valid    <= 1'b1;
        ray_ch.origin_x <= r.ox;
        ray_ch.origin_y <= r.oy;
        ray_ch.origin_z <= r.oz;
        ray_ch.dir_x    <= r.dx;
        ray_ch.dir_y    <= r.dy;
        ray_ch.dir_z    <= r.dz;
        ray_ch.t_min    <= r.t_lo;
        ray_ch.t_max    <= r.t_hi;
        @(posedge clk);
        while (!ray_ch.ready)
            @(posedge clk);
        sb.note_ray(r);
    endtask

    function logic signed [31:0] units(int lo, int hi);
        return ($signed($urandom_range(0, hi - lo)) + lo) <<< FRAC;
    endfunction

    function ray_t make_ray();
        ray_t r;
        int   kind;
        logic signed [31:0] offx, offy, offz;
        int   sh;
        kind = $urandom_range(99);
        if (kind < 30)
        begin
            r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            return r;
        end
        offx = units(-200, 200);
        offy = units(-200, 200);
        offz = units(-200, 200);
        sh = $urandom_range(0, 6);
        r.ox = sb.cx + offx;
        r.oy = sb.cy + offy;
        r.oz = sb.cz + offz;
        r.dx = -(offx >>> sh) + $signed($urandom_range(0, 1 << 18)) - (1 << 17);
        r.dy = -(offy >>> sh) + $signed($urandom_range(0, 1 << 18)) - (1 << 17);
        r.dz = -(offz >>> sh) + $signed($urandom_range(0, 1 << 18)) - (1 << 17);
        r.t_lo = -$signed($urandom_range(0, 3 << FRAC));
        r.t_hi = $signed($urandom_range(0, 32'h7fff_ffff));
        if (kind >= 90)
        begin
            r.t_lo = $signed($urandom_range(1 << FRAC, 32'h7fff_ffff));
            r.t_hi = r.t_lo - $signed($urandom_range(1, 1 << FRAC));
        end
        else if (kind >= 80)
        begin
            r.t_lo = units(0, 150);
            r.t_hi = r.t_lo + units(0, 50);
        end
        return r;
    endfunction

    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC;
        localparam logic signed [31:0] SMAX = 32'h7fff_ffff;
        localparam logic signed [31:0] SMIN = 32'h8000_0000;
        ray_t r;
        sb = new();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        no_idle = 1'b0;
        ray_ch.valid = 1'b0;
        {ray_ch.origin_x, ray_ch.origin_y, ray_ch.origin_z} = '0;
        {ray_ch.dir_x, ray_ch.dir_y, ray_ch.dir_z, ray_ch.t_min, ray_ch.t_max} = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // registers still at reset: point sphere at the origin
        send_ray('{-ONE, 0, 0, ONE, 0, 0, SMIN, SMAX});
        send_ray('{SMAX, SMAX, SMAX, SMIN, SMIN, SMIN, SMIN, SMAX});

        set_sphere(0, 0, 0, ONE);
        // tangent ray: double root at t = 5
        send_ray('{-5 * ONE, ONE, 0, ONE, 0, 0, 0, SMAX});
        // zero direction
        send_ray('{-5 * ONE, 0, 0, 0, 0, 0, SMIN, SMAX});
        // clear miss, negative discriminant
        send_ray('{-5 * ONE, 3 * ONE, 0, ONE, 0, 0, SMIN, SMAX});
        // straight hit, near root at 4
        send_ray('{-5 * ONE, 0, 0, ONE, 0, 0, 0, SMAX});
        // interval ends on or just inside the roots
        send_ray('{-5 * ONE, 0, 0, ONE, 0, 0, 4 * ONE, 4 * ONE});
        send_ray('{-5 * ONE, 0, 0, ONE, 0, 0, 4 * ONE + 1, 6 * ONE});
        send_ray('{-5 * ONE, 0, 0, ONE, 0, 0, 4 * ONE + 1, 6 * ONE - 1});
        // origin inside: near root negative; far root taken when t_min is zero
        send_ray('{0, 0, 0, ONE, 0, 0, 0, SMAX});
        send_ray('{0, 0, 0, ONE, 0, 0, SMIN, SMAX});
        // empty interval
        send_ray('{-5 * ONE, 0, 0, ONE, 0, 0, 6 * ONE, 4 * ONE});
        // tiny direction: roots beyond 32 bits
        send_ray('{-5 * ONE, 0, 0, 1, 0, 0, SMIN, SMAX});
        // sphere behind the ray
        send_ray('{5 * ONE, 0, 0, ONE, 0, 0, 0, SMAX});
        // field extremes
        send_ray('{SMIN, SMIN, SMIN, SMAX, SMAX, SMAX, SMIN, SMAX});
        send_ray('{SMAX, SMAX, SMAX, SMIN, SMIN, SMIN, SMIN, SMAX});
        send_ray('{SMAX, SMIN, 0, SMIN, SMAX, 1, SMAX, SMIN});
        send_ray('{-1, -1, -1, -1, -1, -1, -1, -1});

        set_sphere(SMAX, SMIN, SMAX, 32'hffff_ffff);
        send_ray('{SMIN, SMAX, SMIN, SMAX, SMIN, SMAX, SMIN, SMAX});
        send_ray('{0, 0, 0, ONE, -ONE, ONE, SMIN, SMAX});
        repeat (80) send_ray(make_ray());

        set_sphere(SMIN, SMAX, SMIN, 0);
        send_ray('{SMIN, SMAX, SMIN, ONE, 0, 0, SMIN, SMAX});
        repeat (80) send_ray(make_ray());

        for (int ph = 0; ph < 6; ph++)
        begin
            set_sphere(units(-100, 100), units(-100, 100), units(-100, 100),
                       (ph == 5) ? $urandom : units(1, 60));
            for (int n = 0; n < 170; n++)
            begin
                no_idle = (ph == 2);
                if (ph == 3 && n == 85)
                begin
                    ray_ch.valid <= 1'b0;
                    @(posedge clk);
                    while (sb.hits_due.size() != 0)
                        @(posedge clk);
                end
                send_ray(make_ray());
            end
        end
        no_idle = 1'b0;

        ray_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.hits_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.hits_due.size() != 0)
            sb.report("results still outstanding at end");
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
